FILE: rtl/free_list_slot_allocator_unit_defines.svh
// ----------------------------------------------------------------------------
// Free-list slot allocator: assertion macros
// Shared concurrent assertion forms, clocked on aclk and idle during reset.
// ----------------------------------------------------------------------------
`ifndef FREE_LIST_SLOT_ALLOCATOR_UNIT_DEFINES_SVH
`define FREE_LIST_SLOT_ALLOCATOR_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FLSA_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define FLSA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error("assertion failed");

`endif

FILE: rtl/flsa_pkg.sv
// ----------------------------------------------------------------------------
// Free-list slot allocator package
// Sizes, operation and status codes, and the request and response types.
// ----------------------------------------------------------------------------
`default_nettype none

package flsa_pkg;

    // Table geometry.
    localparam int SLOTS      = 256;
    localparam int SLOT_BITS  = $clog2(SLOTS);
    localparam int COUNT_BITS = SLOT_BITS + 1;
    localparam int ID_BITS    = 16;

    // Identifier value that marks an empty slot.
    localparam logic [ID_BITS-1:0] EMPTY_ID = {ID_BITS{1'b1}};

    // Operation codes; the unused code behaves as a query.
    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_REMOVE = 2'd1;
    localparam logic [1:0] FUNC_QUERY  = 2'd2;

    // Status codes.
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_RANGE     = 2'd2;
    localparam logic [1:0] STATUS_EMPTY     = 2'd3;

    typedef struct packed {
        logic [1:0]           func;
        logic [SLOT_BITS-1:0] slot_index;
        logic [ID_BITS-1:0]   global_id;
    } req_t;

    typedef struct packed {
        logic [SLOT_BITS-1:0]  slot_out;
        logic [ID_BITS-1:0]    stored_id;
        logic                  slot_valid;
        logic [COUNT_BITS-1:0] table_size;
        logic [1:0]            status;
    } rsp_t;

    // Sequencer states, one-hot.
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/flsa_ram.sv
// ----------------------------------------------------------------------------
// Free-list slot allocator RAM
// Simple dual-port synchronous RAM with one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module flsa_ram #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 1,
    localparam int ADDR_BITS = $clog2(DEPTH)
) (
    input  wire logic                 aclk,
    input  wire logic                 wr_en,
    input  wire logic [ADDR_BITS-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]     wr_data,
    input  wire logic                 rd_en,
    input  wire logic [ADDR_BITS-1:0] rd_addr,
    output logic      [WIDTH-1:0]     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; the data holds while no read is issued.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/free_list_slot_allocator_unit.sv
// Timing: an accepted request reads the table and stack RAMs as it is taken, and the
// write-back state then registers the response; s_ready stays low until the write-back
// completes, and the write-back waits while a pending response is not taken by m_ready.
// Reset: aresetn clears the free count, the high-water mark, the sequencer and the
// response valid. The RAMs are not cleared; only written entries are ever used.
// ----------------------------------------------------------------------------
// Free-list slot allocator
// Slot table with a LIFO free stack, both held in RAMs, driven by a two-state
// read-modify-write sequencer with a registered response.
// ----------------------------------------------------------------------------
`default_nettype none

`include "free_list_slot_allocator_unit_defines.svh"

module free_list_slot_allocator_unit (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire flsa_pkg::req_t s_req,
    output logic               m_valid,
    input  wire logic          m_ready,
    output flsa_pkg::rsp_t     m_rsp
);

    localparam int SB = flsa_pkg::SLOT_BITS;
    localparam int CB = flsa_pkg::COUNT_BITS;
    localparam int IB = flsa_pkg::ID_BITS;

    flsa_pkg::state_t state_reg, state_next;
    logic [CB-1:0]    free_count_reg, free_count_next;
    logic [CB-1:0]    high_water_reg, high_water_next;
    flsa_pkg::req_t   req_reg;
    flsa_pkg::rsp_t   rsp_reg, rsp_next;
    logic             m_valid_reg, m_valid_next;

    logic          accept;
    logic          tbl_we, stk_we;
    logic [SB-1:0] tbl_waddr, stk_waddr, stk_waddr_unused;
    logic [IB-1:0] tbl_wdata, tbl_rdata;
    logic [SB-1:0] stk_wdata, stk_rdata, stk_raddr;
    logic          in_range;

    assign s_ready = (state_reg == flsa_pkg::ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_rsp   = rsp_reg;

    // The stack top sits one below the free count.
    assign stk_raddr = SB'(free_count_reg - CB'(1));
    assign stk_waddr_unused = '0;

    // Slot table RAM.
    flsa_ram #(.DEPTH(flsa_pkg::SLOTS), .WIDTH(IB)) u_table_ram (
        .aclk    (aclk),
        .wr_en   (tbl_we),
        .wr_addr (tbl_waddr),
        .wr_data (tbl_wdata),
        .rd_en   (accept),
        .rd_addr (s_req.slot_index),
        .rd_data (tbl_rdata)
    );

    // Free stack RAM.
    flsa_ram #(.DEPTH(flsa_pkg::SLOTS), .WIDTH(SB)) u_stack_ram (
        .aclk    (aclk),
        .wr_en   (stk_we),
        .wr_addr (stk_waddr | stk_waddr_unused),
        .wr_data (stk_wdata),
        .rd_en   (accept),
        .rd_addr (stk_raddr),
        .rd_data (stk_rdata)
    );

    assign in_range = ({1'b0, req_reg.slot_index} < high_water_reg);

    // Sequencer: read in the accepting cycle, then modify and write back in ST_EXEC once the response register is free.
    always_comb begin
        state_next      = state_reg;
        free_count_next = free_count_reg;
        high_water_next = high_water_reg;
        rsp_next        = rsp_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        tbl_we          = 1'b0;
        tbl_waddr       = req_reg.slot_index;
        tbl_wdata       = flsa_pkg::EMPTY_ID;
        stk_we          = 1'b0;
        stk_waddr       = SB'(free_count_reg);
        stk_wdata       = req_reg.slot_index;

        case (state_reg)
            flsa_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = flsa_pkg::ST_EXEC;
                end
            end
            flsa_pkg::ST_EXEC: begin
                if (!m_valid_reg || m_ready) begin
                    state_next          = flsa_pkg::ST_IDLE;
                    m_valid_next        = 1'b1;
                    rsp_next.slot_out   = req_reg.slot_index;
                    rsp_next.stored_id  = '0;
                    rsp_next.slot_valid = 1'b0;
                    rsp_next.status     = flsa_pkg::STATUS_OK;
                    case (req_reg.func)
                        flsa_pkg::FUNC_INSERT: begin
                            rsp_next.stored_id  = req_reg.global_id;
                            rsp_next.slot_valid = (req_reg.global_id != flsa_pkg::EMPTY_ID);
                            tbl_wdata           = req_reg.global_id;
                            if (free_count_reg != '0) begin
                                // Reuse the most recently freed slot.
                                free_count_next   = free_count_reg - CB'(1);
                                rsp_next.slot_out = stk_rdata;
                                tbl_waddr         = stk_rdata;
                                tbl_we            = 1'b1;
                            end else if (high_water_reg != CB'(flsa_pkg::SLOTS)) begin
                                // Append a fresh slot at the high-water mark.
                                high_water_next   = high_water_reg + CB'(1);
                                rsp_next.slot_out = SB'(high_water_reg);
                                tbl_waddr         = SB'(high_water_reg);
                                tbl_we            = 1'b1;
                            end else begin
                                rsp_next.slot_out   = '0;
                                rsp_next.stored_id  = '0;
                                rsp_next.slot_valid = 1'b0;
                                rsp_next.status     = flsa_pkg::STATUS_FULL;
                            end
                        end
                        flsa_pkg::FUNC_REMOVE: begin
                            if (!in_range) begin
                                rsp_next.status = flsa_pkg::STATUS_RANGE;
                            end else begin
                                rsp_next.stored_id = flsa_pkg::EMPTY_ID;
                                if (tbl_rdata == flsa_pkg::EMPTY_ID) begin
                                    rsp_next.status = flsa_pkg::STATUS_EMPTY;
                                end else begin
                                    // Mark the slot empty and push it on the stack.
                                    tbl_we = 1'b1;
                                    if (free_count_reg != CB'(flsa_pkg::SLOTS)) begin
                                        stk_we          = 1'b1;
                                        free_count_next = free_count_reg + CB'(1);
                                    end
                                end
                            end
                        end
                        default: begin
                            if (!in_range) begin
                                rsp_next.status = flsa_pkg::STATUS_RANGE;
                            end else begin
                                rsp_next.stored_id  = tbl_rdata;
                                rsp_next.slot_valid = (tbl_rdata != flsa_pkg::EMPTY_ID);
                            end
                        end
                    endcase
                    rsp_next.table_size = high_water_next;
                end
            end
            default: begin
                state_next = flsa_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= flsa_pkg::ST_IDLE;
            free_count_reg <= '0;
            high_water_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            free_count_reg <= free_count_next;
            high_water_reg <= high_water_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers: the captured request and the response.
    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg <= s_req;
        end
        rsp_reg <= rsp_next;
    end

    // The stack never holds more slots than have been handed out.
    `FLSA_ASSERT_SAME(a_free_within_hw, 1'b1, free_count_reg <= high_water_reg)
    // The high-water mark never passes the table size.
    `FLSA_ASSERT_SAME(a_hw_bounded, 1'b1, high_water_reg <= CB'(flsa_pkg::SLOTS))
    // An accepted request always moves the sequencer to its write-back cycle.
    `FLSA_ASSERT_NEXT(a_accept_exec, accept, state_reg == flsa_pkg::ST_EXEC)
    // A new response only appears from the write-back cycle.
    `FLSA_ASSERT_SAME(a_rsp_from_exec, $rose(m_valid_reg), $past(state_reg) == flsa_pkg::ST_EXEC)

endmodule

`default_nettype wire
